/* rtl/core/rmq_pkg.sv */
// shared types and codes for the rotation matrix to quaternion converter
`timescale 1ns / 1ps
`default_nettype none
package rmq_pkg;

	localparam int ELEM_W = 16;
	localparam int NUM_W  = 18;

	// branch codes: which component comes from the square root
	localparam logic [1:0] BR_TRACE = 2'd0;
	localparam logic [1:0] BR_X     = 2'd1;
	localparam logic [1:0] BR_Y     = 2'd2;
	localparam logic [1:0] BR_Z     = 2'd3;

	typedef struct packed {
		logic signed [ELEM_W-1:0] r00;
		logic signed [ELEM_W-1:0] r01;
		logic signed [ELEM_W-1:0] r02;
		logic signed [ELEM_W-1:0] r10;
		logic signed [ELEM_W-1:0] r11;
		logic signed [ELEM_W-1:0] r12;
		logic signed [ELEM_W-1:0] r20;
		logic signed [ELEM_W-1:0] r21;
		logic signed [ELEM_W-1:0] r22;
	} matrix_t;

	typedef struct packed {
		logic signed [ELEM_W-1:0] quat_x;
		logic signed [ELEM_W-1:0] quat_y;
		logic signed [ELEM_W-1:0] quat_z;
		logic signed [ELEM_W-1:0] quat_w;
	} quat_t;

	// side data riding along the square root cells
	typedef struct packed {
		logic                         valid;
		logic [1:0]                   br;
		logic [2:0][NUM_W-1:0]        num;
	} sq_side_t;

	// side data riding along the divider cells
	typedef struct packed {
		logic       valid;
		logic [1:0] br;
		logic       sq0;
		logic [2:0] neg;
		logic [2:0] nz;
	} div_side_t;

endpackage
`default_nettype wire

/* rtl/core/rmq_prep.sv */
// input stage: branch choice, radicand and the three numerators
`timescale 1ns / 1ps
`default_nettype none
module rmq_prep import rmq_pkg::*; #(
	parameter int FRAC_BITS = 14,
	parameter int RW2 = 2 * FRAC_BITS + 20
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire matrix_t        matrix,
	output sq_side_t            side_s1,
	output logic [RW2-1:0]      rad_s1
);
	localparam int VSW = FRAC_BITS + 20;
	localparam int UW  = VSW - 1;

	logic signed [VSW-1:0] e00, e11, e22, one_v, t, v;
	logic [1:0]            br;
	logic [2:0][NUM_W-1:0] num;
	logic [UW-1:0]         v_u;

	always_comb begin
		e00   = VSW'(matrix.r00);
		e11   = VSW'(matrix.r11);
		e22   = VSW'(matrix.r22);
		one_v = VSW'(1) <<< FRAC_BITS;
		t     = e00 + e11 + e22;
		if (t > 0) begin
			br = BR_TRACE;
		end else if (e00 > e11 && e00 > e22) begin
			br = BR_X;
		end else if (e11 > e22) begin
			br = BR_Y;
		end else begin
			br = BR_Z;
		end
		// numerators ordered as the non-diagonal components in x, y, z, w order
		case (br)
			BR_TRACE: begin
				v      = one_v + t;
				num[0] = NUM_W'(matrix.r21) - NUM_W'(matrix.r12);
				num[1] = NUM_W'(matrix.r02) - NUM_W'(matrix.r20);
				num[2] = NUM_W'(matrix.r10) - NUM_W'(matrix.r01);
			end
			BR_X: begin
				v      = one_v + e00 - e11 - e22;
				num[0] = NUM_W'(matrix.r01) + NUM_W'(matrix.r10);
				num[1] = NUM_W'(matrix.r02) + NUM_W'(matrix.r20);
				num[2] = NUM_W'(matrix.r21) - NUM_W'(matrix.r12);
			end
			BR_Y: begin
				v      = one_v + e11 - e00 - e22;
				num[0] = NUM_W'(matrix.r01) + NUM_W'(matrix.r10);
				num[1] = NUM_W'(matrix.r12) + NUM_W'(matrix.r21);
				num[2] = NUM_W'(matrix.r02) - NUM_W'(matrix.r20);
			end
			default: begin
				v      = one_v + e22 - e00 - e11;
				num[0] = NUM_W'(matrix.r02) + NUM_W'(matrix.r20);
				num[1] = NUM_W'(matrix.r12) + NUM_W'(matrix.r21);
				num[2] = NUM_W'(matrix.r10) - NUM_W'(matrix.r01);
			end
		endcase
		// negative radicand clamps to zero
		v_u = v[VSW-1] ? '0 : v[UW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1.valid <= 1'b0;
		end else begin
			side_s1.valid <= start;
			side_s1.br    <= br;
			side_s1.num   <= num;
			rad_s1        <= RW2'({v_u, {FRAC_BITS{1'b0}}});
		end
	end

endmodule
`default_nettype wire

/* rtl/core/rmq_sqrt_cell.sv */
// one digit cell of the pipelined integer square root
`timescale 1ns / 1ps
`default_nettype none
module rmq_sqrt_cell import rmq_pkg::*; #(
	parameter int RW2 = 48,
	parameter int SW  = 24
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire sq_side_t        side_i,
	input  wire logic [RW2-1:0]  rad_i,
	input  wire logic [SW+1:0]   rem_i,
	input  wire logic [SW-1:0]   root_i,
	output sq_side_t             side_o,
	output logic [RW2-1:0]       rad_o,
	output logic [SW+1:0]        rem_o,
	output logic [SW-1:0]        root_o
);
	logic [SW+1:0] rem_n, trial;
	logic          ge;

	always_comb begin
		rem_n = {rem_i[SW-1:0], rad_i[RW2-1 -: 2]};
		trial = {root_i, 2'b01};
		ge    = rem_n >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_o.valid <= 1'b0;
		end else begin
			side_o.valid <= side_i.valid;
			side_o.br    <= side_i.br;
			side_o.num   <= side_i.num;
			rad_o        <= rad_i << 2;
			rem_o        <= ge ? rem_n - trial : rem_n;
			root_o       <= {root_i[SW-2:0], ge};
		end
	end

endmodule
`default_nettype wire

/* rtl/core/rmq_div_cell.sv */
// one quotient bit cell for three restoring divisions sharing a divisor
`timescale 1ns / 1ps
`default_nettype none
module rmq_div_cell import rmq_pkg::*; #(
	parameter int NW  = 33,
	parameter int DW  = 25,
	parameter int QB  = 32,
	parameter int BIT = 0
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire div_side_t            side_i,
	input  wire logic [DW-1:0]        den_i,
	input  wire logic [DW-1:0]        diag_i,
	input  wire logic [2:0][NW-1:0]   rem_i,
	input  wire logic [2:0][QB-1:0]   q_i,
	output div_side_t                 side_o,
	output logic [DW-1:0]             den_o,
	output logic [DW-1:0]             diag_o,
	output logic [2:0][NW-1:0]        rem_o,
	output logic [2:0][QB-1:0]        q_o
);
	localparam int CW = NW + DW;

	logic [CW-1:0]  dsh;
	logic [2:0]     ge;

	always_comb begin
		dsh = CW'(den_i) << BIT;
		for (int j = 0; j < 3; j++) begin
			ge[j] = CW'(rem_i[j]) >= dsh;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_o.valid <= 1'b0;
		end else begin
			side_o.valid <= side_i.valid;
			side_o.br    <= side_i.br;
			side_o.sq0   <= side_i.sq0;
			side_o.neg   <= side_i.neg;
			side_o.nz    <= side_i.nz;
			den_o        <= den_i;
			diag_o       <= diag_i;
			for (int j = 0; j < 3; j++) begin
				rem_o[j] <= ge[j] ? rem_i[j] - dsh[NW-1:0] : rem_i[j];
				q_o[j]   <= {q_i[j][QB-2:0], ge[j]};
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/core/rotation_matrix_to_quaternion_top.sv */
// rotation matrix to quaternion converter, top level
// throughput: one matrix per cycle, busy is never raised
// latency is set by the chain of square root cells (one root bit each) and
// the chain of divider cells (one quotient bit each) that follow it
// reset clears every valid flag in the pipeline; data registers are not reset
// the receiver cannot stall: done is a one-cycle strobe
`timescale 1ns / 1ps
`default_nettype none
module rotation_matrix_to_quaternion_top import rmq_pkg::*; #(
	parameter int FRAC_BITS = 14
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	output logic         busy,
	input  wire matrix_t matrix,
	output logic         done,
	output quat_t        quat
);
	// radicand width (even), root width, dividend width, divisor width, quotient bits
	localparam int RW2 = 2 * FRAC_BITS + 20;
	localparam int SW  = RW2 / 2;
	localparam int NW  = FRAC_BITS + 19;
	localparam int DW  = SW + 1;
	localparam int QB  = NW - 1;
	localparam int OW  = FRAC_BITS + 2;
	localparam int MW  = NUM_W - 1;
	localparam int LAT = SW + QB + 3;

	// the pipeline never blocks a request
	assign busy = 1'b0;

	// square root chain: one root bit per cell
	sq_side_t               sq_side [SW+1];
	logic [SW:0][RW2-1:0]   rad_s;
	logic [SW:0][SW+1:0]    rem_s;
	logic [SW:0][SW-1:0]    root_s;

	rmq_prep #(.FRAC_BITS(FRAC_BITS), .RW2(RW2)) u_prep (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.matrix  (matrix),
		.side_s1 (sq_side[0]),
		.rad_s1  (rad_s[0])
	);
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;

	for (genvar k = 0; k < SW; k++) begin : g_sqrt
		rmq_sqrt_cell #(.RW2(RW2), .SW(SW)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.side_i (sq_side[k]),
			.rad_i  (rad_s[k]),
			.rem_i  (rem_s[k]),
			.root_i (root_s[k]),
			.side_o (sq_side[k+1]),
			.rad_o  (rad_s[k+1]),
			.rem_o  (rem_s[k+1]),
			.root_o (root_s[k+1])
		);
	end

	// divider setup: dividend = |num| * ONE + sq (rounding), divisor = 2*sq
	div_side_t              div_side [QB+1];
	logic [QB:0][DW-1:0]    den_s, diag_s;
	logic [QB:0][2:0][NW-1:0] nrem_s;
	logic [QB:0][2:0][QB-1:0] q_s;

	div_side_t              div_in_q;
	logic [DW-1:0]          den_in_q, diag_in_q;
	logic [2:0][NW-1:0]     nrem_in_q;

	logic [SW-1:0]          sq;
	logic [2:0][MW-1:0]     mag;
	logic [2:0]             neg;

	always_comb begin
		sq = root_s[SW];
		for (int j = 0; j < 3; j++) begin
			neg[j] = sq_side[SW].num[j][NUM_W-1];
			mag[j] = neg[j] ? MW'(-sq_side[SW].num[j]) : sq_side[SW].num[j][MW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_in_q.valid <= 1'b0;
		end else begin
			div_in_q.valid <= sq_side[SW].valid;
			div_in_q.br    <= sq_side[SW].br;
			div_in_q.sq0   <= sq == '0;
			div_in_q.neg   <= neg;
			den_in_q       <= {sq, 1'b0};
			// diagonal component: sq/2 rounded half up
			diag_in_q      <= DW'(({1'b0, sq} + DW'(1)) >> 1);
			for (int j = 0; j < 3; j++) begin
				div_in_q.nz[j] <= mag[j] != '0;
				nrem_in_q[j]   <= (NW'(mag[j]) << FRAC_BITS) + NW'(sq);
			end
		end
	end

	assign div_side[0] = div_in_q;
	assign den_s[0]    = den_in_q;
	assign diag_s[0]   = diag_in_q;
	assign nrem_s[0]   = nrem_in_q;
	assign q_s[0]      = '0;

	// divider chain: one quotient bit per cell, most significant first
	for (genvar k = 0; k < QB; k++) begin : g_div
		rmq_div_cell #(.NW(NW), .DW(DW), .QB(QB), .BIT(QB - 1 - k)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.side_i (div_side[k]),
			.den_i  (den_s[k]),
			.diag_i (diag_s[k]),
			.rem_i  (nrem_s[k]),
			.q_i    (q_s[k]),
			.side_o (div_side[k+1]),
			.den_o  (den_s[k+1]),
			.diag_o (diag_s[k+1]),
			.rem_o  (nrem_s[k+1]),
			.q_o    (q_s[k+1])
		);
	end

	// output stage: sign, saturation and placement by branch
	div_side_t              fin;
	logic signed [OW-1:0]   one_o;
	logic signed [OW-1:0]   lane [3];
	logic signed [OW-1:0]   dval;
	logic [QB-1:0]          qs;
	logic [DW-1:0]          dsat;
	quat_t                  quat_n;

	always_comb begin
		fin   = div_side[QB];
		one_o = OW'(1) <<< FRAC_BITS;
		for (int j = 0; j < 3; j++) begin
			qs = (q_s[QB][j] > QB'(one_o)) ? QB'(one_o) : q_s[QB][j];
			if (fin.sq0) begin
				// zero divisor: unit value carrying the numerator's sign, zero for a zero numerator
				lane[j] = !fin.nz[j] ? '0 : (fin.neg[j] ? -one_o : one_o);
			end else begin
				lane[j] = fin.neg[j] ? -OW'(qs) : OW'(qs);
			end
		end
		dsat = (diag_s[QB] > DW'(one_o)) ? DW'(one_o) : diag_s[QB];
		dval = OW'(dsat);
		case (fin.br)
			BR_TRACE: begin
				quat_n.quat_x = ELEM_W'(lane[0]);
				quat_n.quat_y = ELEM_W'(lane[1]);
				quat_n.quat_z = ELEM_W'(lane[2]);
				quat_n.quat_w = ELEM_W'(dval);
			end
			BR_X: begin
				quat_n.quat_x = ELEM_W'(dval);
				quat_n.quat_y = ELEM_W'(lane[0]);
				quat_n.quat_z = ELEM_W'(lane[1]);
				quat_n.quat_w = ELEM_W'(lane[2]);
			end
			BR_Y: begin
				quat_n.quat_x = ELEM_W'(lane[0]);
				quat_n.quat_y = ELEM_W'(dval);
				quat_n.quat_z = ELEM_W'(lane[1]);
				quat_n.quat_w = ELEM_W'(lane[2]);
			end
			default: begin
				quat_n.quat_x = ELEM_W'(lane[0]);
				quat_n.quat_y = ELEM_W'(lane[1]);
				quat_n.quat_z = ELEM_W'(dval);
				quat_n.quat_w = ELEM_W'(lane[2]);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= fin.valid;
		end
	end

	always_ff @(posedge clk) begin
		quat <= quat_n;
	end

`ifndef SYNTH
	// every accepted request comes out after the fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("request did not complete after fixed latency");

	// every valid that leaves the root chain enters the divider chain
	a_chain: assert property (@(posedge clk) disable iff (!arst_n)
		sq_side[SW].valid |=> div_side[0].valid)
		else $error("valid lost between root and divider chains");

	// busy stays low
	a_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");
`endif

endmodule
`default_nettype wire

/* tb/rmq_checker.sv */
// checker that predicts quaternions from accepted matrices and compares results
`timescale 1ns / 1ps
`default_nettype none
module rmq_checker import rmq_pkg::*; #(
	parameter int FRAC_BITS = 14
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	input  wire logic    busy,
	input  wire matrix_t matrix,
	input  wire logic    done,
	input  wire quat_t   quat,
	output int           errors,
	output int           pending
);
	localparam longint ONE = longint'(1) << FRAC_BITS;

	quat_t quat_q[$];

	function automatic longint root_floor(longint x);
		longint res;
		longint b;
		res = 0;
		b = longint'(1) << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x = x - res - b;
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic longint clamp_one(longint v);
		if (v > ONE) return ONE;
		if (v < -ONE) return -ONE;
		return v;
	endfunction

	function automatic longint ratio(longint num, longint den);
		longint mag;
		longint q;
		mag = (num < 0) ? -num : num;
		if (den == 0) begin
			if (mag == 0) return 0;
			return (num < 0) ? -ONE : ONE;
		end
		q = (mag * ONE + den / 2) / den;
		if (q > ONE) q = ONE;
		return (num < 0) ? -q : q;
	endfunction

	function automatic quat_t convert(matrix_t m);
		longint a00, a01, a02, a10, a11, a12, a20, a21, a22, tr, v, sq, den, hs;
		longint qx, qy, qz, qw;
		quat_t r;
		logic [1:0] br;
		a00 = m.r00; a01 = m.r01; a02 = m.r02;
		a10 = m.r10; a11 = m.r11; a12 = m.r12;
		a20 = m.r20; a21 = m.r21; a22 = m.r22;
		tr = a00 + a11 + a22;
		if (tr > 0) begin
			br = BR_TRACE; v = ONE + tr;
		end else if (a00 > a11 && a00 > a22) begin
			br = BR_X; v = ONE + a00 - a11 - a22;
		end else if (a11 > a22) begin
			br = BR_Y; v = ONE + a11 - a00 - a22;
		end else begin
			br = BR_Z; v = ONE + a22 - a00 - a11;
		end
		if (v < 0) v = 0;
		sq = root_floor(v << FRAC_BITS);
		den = 2 * sq;
		hs = (sq + 1) >> 1;
		case (br)
			BR_TRACE: begin
				qw = hs; qx = ratio(a21 - a12, den);
				qy = ratio(a02 - a20, den); qz = ratio(a10 - a01, den);
			end
			BR_X: begin
				qx = hs; qw = ratio(a21 - a12, den);
				qy = ratio(a01 + a10, den); qz = ratio(a02 + a20, den);
			end
			BR_Y: begin
				qy = hs; qw = ratio(a02 - a20, den);
				qx = ratio(a01 + a10, den); qz = ratio(a12 + a21, den);
			end
			default: begin
				qz = hs; qw = ratio(a10 - a01, den);
				qx = ratio(a02 + a20, den); qy = ratio(a12 + a21, den);
			end
		endcase
		r.quat_x = 16'(clamp_one(qx));
		r.quat_y = 16'(clamp_one(qy));
		r.quat_z = 16'(clamp_one(qz));
		r.quat_w = 16'(clamp_one(qw));
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		quat_t want;
		if (!arst_n) begin
			errors  <= 0;
			pending <= 0;
		end else begin
			if (start && !busy) quat_q.push_back(convert(matrix));
			if (done) begin
				if (quat_q.size() == 0) begin
					$display("%0t: unexpected result %h", $time, quat);
					errors <= errors + 1;
				end else begin
					want = quat_q.pop_front();
					if (want.quat_x !== quat.quat_x || want.quat_y !== quat.quat_y ||
					    want.quat_z !== quat.quat_z || want.quat_w !== quat.quat_w) begin
						$display({"%0t: mismatch expected x %0d y %0d z %0d w %0d,",
							" actual x %0d y %0d z %0d w %0d"},
							$time, want.quat_x, want.quat_y, want.quat_z, want.quat_w,
							quat.quat_x, quat.quat_y, quat.quat_z, quat.quat_w);
						errors <= errors + 1;
					end
				end
			end
			pending <= quat_q.size();
		end
	end

endmodule
`default_nettype wire

/* tb/tb_rotation_matrix_to_quaternion_top.sv */
// testbench top: stimulus for the rotation matrix to quaternion converter and verdict
`timescale 1ns / 1ps
`default_nettype none
module tb_rotation_matrix_to_quaternion_top import rmq_pkg::*; ();

	localparam int  LATENCY   = 2 * 14 + 31;
	localparam int  N_RANDOM  = 2000;
	localparam longint LIMIT  = 400000;

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	matrix_t matrix;
	logic    done;
	quat_t   quat;
	int      errors;
	int      pending;
	longint  cycles = 0;
	int      idle_pct;

	rotation_matrix_to_quaternion_top u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.matrix(matrix), .done(done), .quat(quat)
	);

	rmq_checker u_chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .matrix(matrix),
		.done(done), .quat(quat), .errors(errors), .pending(pending)
	);

	always begin
		clk = 1'b0; #10;
		clk = 1'b1; #10;
	end

	// watchdog, sized for a fully idle sender many times over
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("tb_rotation_matrix_to_quaternion_top failed");
			$finish;
		end
	end

	function automatic logic [15:0] rnd_elem();
		int k;
		k = $urandom_range(0, 9);
		// mostly in range, sometimes any pattern, sometimes the extremes
		if (k < 6) return 16'($urandom_range(0, 32768) - 16384);
		if (k < 8) return 16'($urandom);
		case ($urandom_range(0, 4))
			0: return 16'sd16384;
			1: return -16'sd16384;
			2: return 16'h7fff;
			3: return 16'h8000;
			default: return 16'd0;
		endcase
	endfunction

	// rough rotation built from a random unit-ish quaternion, so every branch shows up
	function automatic matrix_t rnd_rotation();
		real a, b, c, d, n;
		matrix_t m;
		a = $urandom_range(0, 2000) - 1000.0; b = $urandom_range(0, 2000) - 1000.0;
		c = $urandom_range(0, 2000) - 1000.0; d = $urandom_range(0, 2000) - 1000.0;
		n = $sqrt(a*a + b*b + c*c + d*d) + 1.0;
		a = a / n; b = b / n; c = c / n; d = d / n;
		m.r00 = 16'($rtoi(16384.0 * (1 - 2*(c*c + d*d))));
		m.r01 = 16'($rtoi(16384.0 * 2*(b*c - d*a)));
		m.r02 = 16'($rtoi(16384.0 * 2*(b*d + c*a)));
		m.r10 = 16'($rtoi(16384.0 * 2*(b*c + d*a)));
		m.r11 = 16'($rtoi(16384.0 * (1 - 2*(b*b + d*d))));
		m.r12 = 16'($rtoi(16384.0 * 2*(c*d - b*a)));
		m.r20 = 16'($rtoi(16384.0 * 2*(b*d - c*a)));
		m.r21 = 16'($rtoi(16384.0 * 2*(c*d + b*a)));
		m.r22 = 16'($rtoi(16384.0 * (1 - 2*(b*b + c*c))));
		return m;
	endfunction

	// hold one request until the block takes it, with random idle cycles first
	task automatic send(matrix_t m);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start  <= 1'b1;
		matrix <= m;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic send_diag(int a, int b, int c, int off);
		matrix_t m;
		m = '{default: 16'(off)};
		m.r00 = 16'(a); m.r11 = 16'(b); m.r22 = 16'(c);
		send(m);
	endtask

	initial begin
		matrix_t m;
		arst_n   = 1'b0;
		start    = 1'b0;
		matrix   = '0;
		idle_pct = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: identity, half turns about each axis (diagonal branches)
		send_diag(16384, 16384, 16384, 0);
		send_diag(16384, -16384, -16384, 0);
		send_diag(-16384, 16384, -16384, 0);
		send_diag(-16384, -16384, 16384, 0);
		// ties in the diagonal go to the later element
		send_diag(0, 0, 0, 0);
		send_diag(-8192, -8192, -16384, 100);
		send_diag(-16384, -8192, -8192, -100);
		// trace exactly zero and just positive
		send_diag(8192, -8192, 0, 3000);
		send_diag(1, 0, 0, -3000);
		// all-negative diagonal, and extreme element patterns with signed numerators
		send_diag(-16384, -16384, -16384, 0);
		m = '{default: 16'h8000}; m.r12 = 16'h7fff; m.r01 = 16'h7fff; send(m);
		m = '{default: 16'h8000}; m.r21 = 16'h7fff; m.r10 = 16'h7fff; send(m);
		m = '{default: 16'h7fff}; send(m);
		m = '{default: 16'h8000}; send(m);
		m = '{default: 16'hffff}; send(m);
		m = '{default: 16'h0001}; send(m);
		// one diagonal element just above the others, with large off-diagonal numerators
		send_diag(-16383, -16384, -16384, 16384);
		send_diag(-16384, -16384, -16383, -16384);

		// random, cycling through sender idling phases
		for (int phase = 0; phase < 8; phase++) begin
			case (phase % 4)
				0: idle_pct = 0;
				1: idle_pct = 69;
				2: idle_pct = 26;
				default: idle_pct = $urandom_range(0, 90);
			endcase
			for (int i = 0; i < N_RANDOM / 8; i++) begin
				if ($urandom_range(0, 3) != 0) begin
					m = rnd_rotation();
				end else begin
					m.r00 = rnd_elem(); m.r01 = rnd_elem(); m.r02 = rnd_elem();
					m.r10 = rnd_elem(); m.r11 = rnd_elem(); m.r12 = rnd_elem();
					m.r20 = rnd_elem(); m.r21 = rnd_elem(); m.r22 = rnd_elem();
				end
				send(m);
			end
		end
		start <= 1'b0;

		// drain the pipeline, then a margin for stray results
		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
		if (errors == 0) begin
			$display("tb_rotation_matrix_to_quaternion_top passed");
		end else begin
			$display("tb_rotation_matrix_to_quaternion_top failed");
		end
		$finish;
	end
endmodule
`default_nettype wire

/* rotation_matrix_to_quaternion_top.f */
rtl/core/rmq_pkg.sv
rtl/core/rmq_prep.sv
rtl/core/rmq_sqrt_cell.sv
rtl/core/rmq_div_cell.sv
rtl/core/rotation_matrix_to_quaternion_top.sv
tb/rmq_checker.sv
tb/tb_rotation_matrix_to_quaternion_top.sv
